@@ rtl/handle_slot_table_top_defines.svh @@
// ----------------------------------------------------------------------------
// handle_slot_table_top_defines.svh
// Assertion macros used by the handle slot table RTL.
// ----------------------------------------------------------------------------
`ifndef HANDLE_SLOT_TABLE_TOP_DEFINES_SVH
`define HANDLE_SLOT_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("handle slot table assertion failed");

// Next-cycle implication, checked outside reset.
`define HST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("handle slot table assertion failed");

`endif

@@ rtl/hst_pkg.sv @@
// ----------------------------------------------------------------------------
// hst_pkg
// Types and constants of the handle slot table.
// ----------------------------------------------------------------------------
package hst_pkg;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 6;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT = 2'd0,
    KIND_POP = 2'd1,
    KIND_CLR = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_e;

endpackage

@@ rtl/handle_slot_table_top.sv @@
// ----------------------------------------------------------------------------
// handle_slot_table_top
// Fixed-capacity handle table with a LIFO free list of released slots.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless a result that is not yet taken stalls
// it, and returns one result per request. A request is held in the input
// register while the result register holds a result that is not yet taken,
// and its result is presented from the result register (input register, then
// result register). Each request is a single read-modify-write of the slot
// memories: the payload and live-flag reads are launched at the input
// transfer, the free-list link at the current head is kept read every cycle,
// and writes of the request ahead are forwarded into those reads. No clearing
// pass is needed after reset: slots at or above the used count are never used,
// and the table shrinks to empty whenever the last live slot is popped.
`include "handle_slot_table_top_defines.svh"

module handle_slot_table_top #(
  parameter int CAPACITY      = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hst_pkg::KIND_W-1:0]    kind_i,
  input  logic [hst_pkg::KEY_W-1:0]     key_i,
  input  logic [hst_pkg::DATA_W-1:0]    payload_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hst_pkg::STATUS_W-1:0]  status_o,
  output logic [hst_pkg::KEY_W-1:0]     slot_key_o,
  output logic [hst_pkg::DATA_W-1:0]    data_out_o
);

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SW     = (PAYLOAD_WIDTH < hst_pkg::DATA_W) ? PAYLOAD_WIDTH
                                                             : hst_pkg::DATA_W;
  localparam int CMP_W  = CNT_W + hst_pkg::KEY_W;

  // slot memories
  logic [SW-1:0]     pay_mem  [CAPACITY];
  logic [SLOT_W-1:0] link_mem [CAPACITY];
  logic              live_mem [CAPACITY];

  // input stage
  logic                       v1_q;
  logic [hst_pkg::KIND_W-1:0] kind1_q;
  logic [hst_pkg::KEY_W-1:0]  key1_q;
  logic [SW-1:0]              pay1_q;
  logic [SW-1:0]              pay_rd_q;
  logic                       live_rd_q;
  logic [SLOT_W-1:0]          link_rd_q;

  // table state
  logic [SLOT_W-1:0] free_head_q, free_head_d;
  logic              free_ne_q, free_ne_d;
  logic [CNT_W-1:0]  slots_used_q, slots_used_d;
  logic [CNT_W-1:0]  live_cnt_q, live_cnt_d;

  // result register
  logic                         ov_q;
  logic [hst_pkg::STATUS_W-1:0] out_status_q;
  logic [hst_pkg::KEY_W-1:0]    out_key_q;
  logic [hst_pkg::DATA_W-1:0]   out_data_q;

  // processing
  logic                       accept;
  logic                       proc_en;
  logic [SLOT_W-1:0]          in_slot;
  logic [SLOT_W-1:0]          key1_slot;
  logic                       key1_in_range;
  hst_pkg::status_e           res_status;
  logic [hst_pkg::KEY_W-1:0]  res_key;
  logic [hst_pkg::DATA_W-1:0] res_data;
  logic                       pay_we, live_we, link_we;
  logic [SLOT_W-1:0]          pay_wa, live_wa;
  logic [SW-1:0]              pay_wd;
  logic                       live_wd;
  logic [SLOT_W-1:0]          put_slot;

  assign proc_en    = v1_q && (!ov_q || out_ready_i);
  assign in_ready_o = !v1_q || proc_en;
  assign accept     = in_valid_i && in_ready_o;

  assign in_slot   = SLOT_W'(key_i);
  assign key1_slot = SLOT_W'(key1_q);
  assign key1_in_range = (CMP_W'(key1_q) < CMP_W'(slots_used_q)) &&
                         (CMP_W'(key1_q) < CMP_W'(CAPACITY));

  always_comb begin
    free_head_d  = free_head_q;
    free_ne_d    = free_ne_q;
    slots_used_d = slots_used_q;
    live_cnt_d   = live_cnt_q;
    res_status   = hst_pkg::ST_NOT_LIVE;
    res_key      = key1_q;
    res_data     = '0;
    pay_we       = 1'b0;
    pay_wa       = key1_slot;
    pay_wd       = pay1_q;
    live_we      = 1'b0;
    live_wa      = key1_slot;
    live_wd      = 1'b0;
    link_we      = 1'b0;
    put_slot     = SLOT_W'(slots_used_q);
    if (proc_en) begin
      unique case (hst_pkg::kind_e'(kind1_q))
        hst_pkg::KIND_PUT: begin
          if (free_ne_q || (slots_used_q < CNT_W'(CAPACITY))) begin
            if (free_ne_q) begin
              put_slot    = free_head_q;
              free_head_d = link_rd_q;
            end else begin
              slots_used_d = slots_used_q + CNT_W'(1);
            end
            live_cnt_d = live_cnt_q + CNT_W'(1);
            free_ne_d  = slots_used_d > live_cnt_d;
            live_we    = 1'b1;
            live_wa    = put_slot;
            live_wd    = 1'b1;
            pay_we     = 1'b1;
            pay_wa     = put_slot;
            pay_wd     = pay1_q;
            res_status = hst_pkg::ST_OK;
            res_key    = hst_pkg::KEY_W'(put_slot);
          end else begin
            res_status = hst_pkg::ST_FULL;
          end
        end
        hst_pkg::KIND_POP: begin
          if (key1_in_range) begin
            if (live_rd_q) begin
              res_status       = hst_pkg::ST_OK;
              res_data[SW-1:0] = pay_rd_q;
              live_we          = 1'b1;
              link_we          = 1'b1;
              free_head_d      = key1_slot;
              free_ne_d        = 1'b1;
              live_cnt_d       = live_cnt_q - CNT_W'(1);
            end
            // last live slot gone: shrink back to an empty table
            if (live_cnt_d == '0) begin
              slots_used_d = '0;
              free_head_d  = '0;
              free_ne_d    = 1'b0;
            end
          end
        end
        hst_pkg::KIND_CLR: begin
          if (key1_in_range && live_rd_q) begin
            res_status = hst_pkg::ST_OK;
            pay_we     = 1'b1;
            pay_wd     = '0;
          end
        end
        default: begin
          res_status = hst_pkg::ST_NOT_LIVE;
        end
      endcase
    end
  end

  // memories, with write data forwarded into a read of the same slot
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_wa] <= pay_wd;
    end
    if (live_we) begin
      live_mem[live_wa] <= live_wd;
    end
    if (link_we) begin
      link_mem[key1_slot] <= free_head_q;
    end
    if (accept) begin
      pay_rd_q  <= (pay_we && (pay_wa == in_slot)) ? pay_wd : pay_mem[in_slot];
      live_rd_q <= (live_we && (live_wa == in_slot)) ? live_wd : live_mem[in_slot];
    end
    // link of the free-list head is always kept at hand
    link_rd_q <= (link_we && (key1_slot == free_head_d)) ? free_head_q
                                                         : link_mem[free_head_d];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind1_q <= kind_i;
      key1_q  <= key_i;
      pay1_q  <= payload_i[SW-1:0];
    end
    if (proc_en) begin
      out_status_q <= res_status;
      out_key_q    <= res_key;
      out_data_q   <= res_data;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      ov_q         <= 1'b0;
      free_head_q  <= '0;
      free_ne_q    <= 1'b0;
      slots_used_q <= '0;
      live_cnt_q   <= '0;
    end else begin
      if (accept) begin
        v1_q <= 1'b1;
      end else if (proc_en) begin
        v1_q <= 1'b0;
      end
      if (proc_en) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      free_head_q  <= free_head_d;
      free_ne_q    <= free_ne_d;
      slots_used_q <= slots_used_d;
      live_cnt_q   <= live_cnt_d;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o    = out_status_q;
  assign slot_key_o  = out_key_q;
  assign data_out_o  = out_data_q;

  `HST_ASSERT_IMPL(a_live_le_used, 1'b1, live_cnt_q <= slots_used_q)
  `HST_ASSERT_IMPL(a_free_ne_match, 1'b1, free_ne_q == (slots_used_q > live_cnt_q))
  `HST_ASSERT_IMPL(a_full_only_when_full, proc_en && (res_status == hst_pkg::ST_FULL),
                   (slots_used_q == CNT_W'(CAPACITY)) && !free_ne_q)
  `HST_ASSERT_NEXT(a_full_no_change, proc_en && (res_status == hst_pkg::ST_FULL),
                   $stable(slots_used_q) && $stable(live_cnt_q))
  `HST_ASSERT_IMPL(a_ready_when_out_empty, !ov_q, in_ready_o)

endmodule

@@ dv/tb_handle_slot_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handle_slot_table_top
// Self-checking bench for the handle slot table. A request-level predictor of
// the slot store and LIFO free list forms each expected response when a request
// transfer happens. A checker compares every response transfer against the
// oldest pending expectation. Both handshake sides idle at random, and one
// phase applies long response backpressure.
// ----------------------------------------------------------------------------
module tb_handle_slot_table_top;

  localparam int          CAPACITY   = 64;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          HOLD_LEN   = 300;
  localparam logic [1:0]  KIND_RSVD  = 2'd3;

  typedef struct packed {
    hst_pkg::status_e           status;
    logic [hst_pkg::KEY_W-1:0]  slot_key;
    logic [hst_pkg::DATA_W-1:0] data;
  } slot_resp_t;

  logic                         clk_i;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic [hst_pkg::KIND_W-1:0]   kind_i      = '0;
  logic [hst_pkg::KEY_W-1:0]    key_i       = '0;
  logic [hst_pkg::DATA_W-1:0]   payload_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [hst_pkg::STATUS_W-1:0] status_o;
  logic [hst_pkg::KEY_W-1:0]    slot_key_o;
  logic [hst_pkg::DATA_W-1:0]   data_out_o;

  handle_slot_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .payload_i   (payload_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .slot_key_o  (slot_key_o),
    .data_out_o  (data_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // predicted table state
  logic [hst_pkg::DATA_W-1:0] slot_data [CAPACITY];
  logic [hst_pkg::KEY_W-1:0]  slot_link [CAPACITY];
  logic                       slot_live [CAPACITY];
  logic [hst_pkg::KEY_W-1:0]  free_top   = '0;
  logic                       free_avail = 1'b0;
  logic [6:0]                 used_cnt   = '0;
  logic [6:0]                 live_cnt   = '0;

  slot_resp_t resp_q[$];
  int         err_cnt      = 0;
  int         req_cnt      = 0;
  int         ok_cnt       = 0;
  int         full_cnt     = 0;
  int         miss_cnt     = 0;
  int         shrink_cnt   = 0;
  bit         idle_on      = 1'b1;
  int         sink_hold    = 0;

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_data[i] = '0;
      slot_link[i] = '0;
      slot_live[i] = 1'b0;
    end
  end

  function automatic slot_resp_t table_step(input logic [hst_pkg::KIND_W-1:0] kind,
                                            input logic [hst_pkg::KEY_W-1:0] key,
                                            input logic [hst_pkg::DATA_W-1:0] word);
    slot_resp_t                r;
    logic [hst_pkg::KEY_W-1:0] slot;
    r.status   = hst_pkg::ST_NOT_LIVE;
    r.slot_key = key;
    r.data     = '0;
    if (kind == hst_pkg::KIND_PUT) begin
      if (free_avail) begin
        slot     = free_top;
        free_top = slot_link[slot];
      end else if (used_cnt < CAPACITY) begin
        slot     = used_cnt[hst_pkg::KEY_W-1:0];
        used_cnt = used_cnt + 7'd1;
      end else begin
        r.status = hst_pkg::ST_FULL;
        return r;
      end
      live_cnt        = live_cnt + 7'd1;
      free_avail      = used_cnt > live_cnt;
      slot_live[slot] = 1'b1;
      slot_data[slot] = word;
      r.status        = hst_pkg::ST_OK;
      r.slot_key      = slot;
    end else if (kind == hst_pkg::KIND_POP) begin
      if (key < used_cnt) begin
        if (slot_live[key]) begin
          r.data         = slot_data[key];
          r.status       = hst_pkg::ST_OK;
          slot_live[key] = 1'b0;
          slot_link[key] = free_top;
          free_top       = key;
          free_avail     = 1'b1;
          live_cnt       = live_cnt - 7'd1;
        end
        // last live slot gone: table shrinks back to empty
        if (live_cnt == 0) begin
          used_cnt   = '0;
          free_top   = '0;
          free_avail = 1'b0;
          shrink_cnt++;
        end
      end
    end else if (kind == hst_pkg::KIND_CLR) begin
      if (key < used_cnt && slot_live[key]) begin
        slot_data[key] = '0;
        r.status       = hst_pkg::ST_OK;
      end
    end
    return r;
  endfunction

  // first live slot at or after start, wrapping; start itself if none
  function automatic logic [hst_pkg::KEY_W-1:0] pick_live_key(
      input logic [hst_pkg::KEY_W-1:0] start);
    logic [hst_pkg::KEY_W-1:0] idx;
    for (int i = 0; i < CAPACITY; i++) begin
      idx = start + i[hst_pkg::KEY_W-1:0];
      if (idx < used_cnt && slot_live[idx]) return idx;
    end
    return start;
  endfunction

  // valid is left high after a transfer so back-to-back requests keep it up
  task automatic send_req(input logic [hst_pkg::KIND_W-1:0] kind,
                          input logic [hst_pkg::KEY_W-1:0] key,
                          input logic [hst_pkg::DATA_W-1:0] word);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    payload_i  <= word;
    do @(posedge clk_i); while (!in_ready_o);
    resp_q.push_back(table_step(kind, key, word));
    req_cnt++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_random(input int put_pct);
    int                         r;
    logic [hst_pkg::KIND_W-1:0] kind;
    logic [hst_pkg::KEY_W-1:0]  key;
    logic [hst_pkg::DATA_W-1:0] word;
    r    = $urandom_range(0, 99);
    word = $urandom();
    case ($urandom_range(0, 15))
      0:       word = '0;
      1:       word = '1;
      default: ;
    endcase
    key = hst_pkg::KEY_W'($urandom_range(0, 63));
    if (r < put_pct) begin
      kind = hst_pkg::KIND_PUT;
    end else if (r < 95) begin
      kind = ($urandom_range(0, 3) == 0) ? hst_pkg::KIND_CLR : hst_pkg::KIND_POP;
      if ($urandom_range(0, 4) != 0) key = pick_live_key(key);
    end else begin
      kind = KIND_RSVD;
    end
    send_req(kind, key, word);
  endtask

  task automatic test_directed();
    // empty table: pop, clear and the reserved kind miss
    send_req(hst_pkg::KIND_POP, 6'd0,  32'h0000_0000);
    send_req(hst_pkg::KIND_CLR, 6'd63, 32'hFFFF_FFFF);
    send_req(KIND_RSVD,         6'd21, 32'h1234_5678);
    send_req(hst_pkg::KIND_PUT, 6'd63, 32'h0000_0000);
    send_req(hst_pkg::KIND_PUT, 6'd0,  32'hFFFF_FFFF);
    send_req(hst_pkg::KIND_PUT, 6'd42, 32'hA5A5_A5A5);
    send_req(hst_pkg::KIND_POP, 6'd0,  32'h0);          // null payload comes back ok
    send_req(hst_pkg::KIND_CLR, 6'd1,  32'h0);
    send_req(hst_pkg::KIND_POP, 6'd1,  32'hFFFF_FFFF);  // cleared slot returns zero
    send_req(hst_pkg::KIND_POP, 6'd1,  32'h0);          // already freed
    send_req(hst_pkg::KIND_CLR, 6'd1,  32'h0);
    send_req(hst_pkg::KIND_CLR, 6'd63, 32'h0);          // beyond used count
    send_req(hst_pkg::KIND_PUT, 6'd0,  32'h1234_5678);  // reuses most recent free slot
    send_req(hst_pkg::KIND_PUT, 6'd0,  32'h8000_0001);
    send_req(hst_pkg::KIND_POP, 6'd5,  32'h0);
    send_req(KIND_RSVD,         6'd63, 32'hFFFF_FFFF);
    send_req(hst_pkg::KIND_POP, 6'd2,  32'h0);
    send_req(hst_pkg::KIND_POP, 6'd1,  32'h0);
    send_req(hst_pkg::KIND_POP, 6'd0,  32'h0);          // last live slot: shrink
    send_req(hst_pkg::KIND_POP, 6'd0,  32'h0);
    send_req(hst_pkg::KIND_PUT, 6'd17, 32'h5A5A_5A5A);
    send_req(hst_pkg::KIND_POP, 6'd0,  32'h0);
  endtask

  task automatic test_fill_and_empty();
    while (!(used_cnt == CAPACITY && !free_avail))
      send_req(hst_pkg::KIND_PUT, hst_pkg::KEY_W'($urandom_range(0, 63)), $urandom());
    send_req(hst_pkg::KIND_PUT, 6'd63, 32'hFFFF_FFFF);
    send_req(hst_pkg::KIND_PUT, 6'd0, 32'h0);
    send_req(hst_pkg::KIND_CLR, pick_live_key(hst_pkg::KEY_W'($urandom_range(0, 63))),
             32'h0);
    send_req(hst_pkg::KIND_PUT, hst_pkg::KEY_W'($urandom_range(0, 63)), $urandom());
    while (live_cnt != 0)
      send_req(hst_pkg::KIND_POP, pick_live_key(hst_pkg::KEY_W'($urandom_range(0, 63))),
               $urandom());
    send_req(hst_pkg::KIND_POP, 6'd63, 32'h0);
  endtask

  task automatic test_backpressure();
    wait_drained();
    idle_on   = 1'b0;
    sink_hold = HOLD_LEN;
    repeat (40) send_random(60);
    idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    int put_pct;
    put_pct = 50;
    for (int n = 0; n < 420; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 3))
          0:       put_pct = 85;
          1:       put_pct = 60;
          2:       put_pct = 40;
          default: put_pct = 20;
        endcase
      end
      idle_on = !(n >= 180 && n < 250);
      if (n == 300) wait_drained();
      send_random(put_pct);
    end
    idle_on = 1'b1;
  endtask

  // response side: random ready gaps, or one long hold when requested
  initial begin : resp_sink
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (sink_hold) @(posedge clk_i);
        sink_hold = 0;
      end else begin
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : resp_check
    slot_resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (resp_q.size() == 0) begin
        $error("unexpected response: status %0d slot_key %0d data_out %h",
               status_o, slot_key_o, data_out_o);
        err_cnt++;
      end else begin
        want = resp_q.pop_front();
        case (want.status)
          hst_pkg::ST_OK:   ok_cnt++;
          hst_pkg::ST_FULL: full_cnt++;
          default:          miss_cnt++;
        endcase
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_cnt++;
        end
        if (slot_key_o !== want.slot_key) begin
          $error("slot_key: expected %0d, got %0d", want.slot_key, slot_key_o);
          err_cnt++;
        end
        if (data_out_o !== want.data) begin
          $error("data_out: expected %h, got %h", want.data, data_out_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck = 0;
      else stuck++;
    end
    $display("[handle_slot_table_top] ERROR");
    $finish;
  end

  initial begin : main
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_fill_and_empty();
    test_backpressure();
    test_random_mix();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (resp_q.size() != 0) begin
      $error("%0d expected responses never arrived", resp_q.size());
      err_cnt++;
    end
    $display("Ran %0d requests: %0d ok, %0d full, %0d not live, %0d shrinks to empty,",
             req_cnt, ok_cnt, full_cnt, miss_cnt, shrink_cnt);
    $display("with random idling, a full table and a %0d-cycle response stall.", HOLD_LEN);
    if (err_cnt == 0) begin
      $display("[handle_slot_table_top] OK");
    end else begin
      $display("[handle_slot_table_top] ERROR");
    end
    $finish;
  end

endmodule
